FILE: design/rdq_pkg.sv
// Shared constants, codes and state type for the priority ready queue.
package rdq_pkg;

  localparam int DEF_QUEUE_DEPTH   = 16;
  localparam int DEF_ID_BITS       = 8;
  localparam int DEF_PRIORITY_BITS = 8;

  typedef enum logic {
    OP_ENQUEUE = 1'b0,
    OP_DEQUEUE = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_FULL  = 2'd1,
    STATUS_EMPTY = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ENQ_WALK,
    ST_ENQ_HEAD,
    ST_DEQ_HEAD,
    ST_DEQ_SHIFT
  } state_t;

endpackage

FILE: design/rdq_store.sv
// Entry store of the ready queue: one write port, one registered read port.
module rdq_store import rdq_pkg::*; #(
  parameter int DEPTH = DEF_QUEUE_DEPTH,
  parameter int WIDTH = DEF_ID_BITS + DEF_PRIORITY_BITS,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write one entry
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read one entry, data valid the next cycle
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

FILE: design/priority_ready_queue.sv
// Top level of the priority ready queue: sequencer, compare unit and result registers.
//
// Usage: a command beat is taken at a rising edge where start is high and busy is
// low. operation selects enqueue (proc_id, proc_priority) or dequeue of the head.
// Every command returns one result beat: done is high for exactly one cycle with
// removed_id, removed_priority, status and occupancy valid in that cycle.
// The queue is kept sorted, highest priority at slot 0, equal priorities in
// arrival order. An enqueue walks the store from the tail toward the head, one
// entry per cycle through the single compare unit and the one-read, one-write
// store, moving each lower-priority entry down one slot until its place is found.
// A dequeue reads the head and then moves every remaining entry up one slot.
// A full enqueue, an empty dequeue or an enqueue into an empty queue shows done in
// the cycle after it is accepted; an enqueue into a non-empty queue walks the store
// and moves k entries (at most QUEUE_DEPTH-1), and a dequeue from n entries moves
// the n-1 entries behind the head. The store port (one entry moved per cycle) paces
// both. busy is high meanwhile; a new command may be taken in the cycle its
// predecessor's done is shown.
// Reset (rst, synchronous) empties the queue; store contents need no clearing.
// The receiver cannot hold results off; done is never delayed.
module priority_ready_queue import rdq_pkg::*; #(
  parameter int QUEUE_DEPTH   = DEF_QUEUE_DEPTH,
  parameter int ID_BITS       = DEF_ID_BITS,
  parameter int PRIORITY_BITS = DEF_PRIORITY_BITS,
  localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1,
  localparam int CW = $clog2(QUEUE_DEPTH + 1),
  localparam int EW = ID_BITS + PRIORITY_BITS
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  output logic                     busy,
  input  logic                     operation,
  input  logic [ID_BITS-1:0]       proc_id,
  input  logic [PRIORITY_BITS-1:0] proc_priority,
  output logic                     done,
  output logic [ID_BITS-1:0]       removed_id,
  output logic [PRIORITY_BITS-1:0] removed_priority,
  output logic [1:0]               status,
  output logic [CW-1:0]            occupancy
);

  state_t                   state, state_next;
  logic [AW-1:0]            idx, idx_next;
  logic [CW-1:0]            count, count_next;
  logic [ID_BITS-1:0]       new_id, new_id_next;
  logic [PRIORITY_BITS-1:0] new_prio, new_prio_next;
  logic                     done_next;
  logic [ID_BITS-1:0]       res_id_next;
  logic [PRIORITY_BITS-1:0] res_prio_next;
  status_t                  res_status, res_status_next;
  logic [CW-1:0]            res_occ_next;

  logic                     we;
  logic [AW-1:0]            waddr, raddr;
  logic [EW-1:0]            wdata, rdata;
  logic [PRIORITY_BITS-1:0] rd_prio;
  logic [ID_BITS-1:0]       rd_id;
  logic                     rd_lower;

  rdq_store #(
    .DEPTH (QUEUE_DEPTH),
    .WIDTH (EW)
  ) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  // split the entry read back; compare against the held priority
  assign rd_prio  = rdata[PRIORITY_BITS-1:0];
  assign rd_id    = rdata[EW-1:PRIORITY_BITS];
  assign rd_lower = rd_prio < new_prio;

  assign busy   = (state != ST_IDLE);
  assign status = res_status;

  // state register and datapath registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      count <= '0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      done  <= done_next;
    end
    idx              <= idx_next;
    new_id           <= new_id_next;
    new_prio         <= new_prio_next;
    removed_id       <= res_id_next;
    removed_priority <= res_prio_next;
    res_status       <= res_status_next;
    occupancy        <= res_occ_next;
  end

  // sequencer: next state, store controls and result values
  always_comb begin
    state_next      = state;
    idx_next        = idx;
    count_next      = count;
    new_id_next     = new_id;
    new_prio_next   = new_prio;
    done_next       = 1'b0;
    res_id_next     = removed_id;
    res_prio_next   = removed_priority;
    res_status_next = res_status;
    res_occ_next    = occupancy;
    we              = 1'b0;
    waddr           = AW'(idx + 1'b1);
    wdata           = {new_id, new_prio};
    raddr           = '0;

    case (state)
      ST_IDLE: begin
        if (start) begin
          new_id_next   = proc_id;
          new_prio_next = proc_priority;
          if (op_t'(operation) == OP_ENQUEUE) begin
            if (count == CW'(QUEUE_DEPTH)) begin
              // full: drop the item
              done_next       = 1'b1;
              res_id_next     = '0;
              res_prio_next   = '0;
              res_status_next = STATUS_FULL;
              res_occ_next    = count;
            end else if (count == '0) begin
              // empty: place at the head at once
              we              = 1'b1;
              waddr           = '0;
              wdata           = {proc_id, proc_priority};
              count_next      = CW'(1);
              done_next       = 1'b1;
              res_id_next     = '0;
              res_prio_next   = '0;
              res_status_next = STATUS_OK;
              res_occ_next    = CW'(1);
            end else begin
              // start the walk at the tail
              raddr      = AW'(count - 1'b1);
              idx_next   = AW'(count - 1'b1);
              state_next = ST_ENQ_WALK;
            end
          end else begin
            if (count == '0) begin
              done_next       = 1'b1;
              res_id_next     = '0;
              res_prio_next   = '0;
              res_status_next = STATUS_EMPTY;
              res_occ_next    = '0;
            end else begin
              raddr      = '0;
              state_next = ST_DEQ_HEAD;
            end
          end
        end
      end

      ST_ENQ_WALK: begin
        we = 1'b1;
        if (rd_lower) begin
          // move the lower entry down one slot and keep walking
          wdata = rdata;
          if (idx == '0) begin
            state_next = ST_ENQ_HEAD;
          end else begin
            raddr    = AW'(idx - 1'b1);
            idx_next = AW'(idx - 1'b1);
          end
        end else begin
          // place the new entry behind this one
          count_next      = CW'(count + 1'b1);
          done_next       = 1'b1;
          res_id_next     = '0;
          res_prio_next   = '0;
          res_status_next = STATUS_OK;
          res_occ_next    = CW'(count + 1'b1);
          state_next      = ST_IDLE;
        end
      end

      ST_ENQ_HEAD: begin
        // new entry outranks all stored ones
        we              = 1'b1;
        waddr           = '0;
        count_next      = CW'(count + 1'b1);
        done_next       = 1'b1;
        res_id_next     = '0;
        res_prio_next   = '0;
        res_status_next = STATUS_OK;
        res_occ_next    = CW'(count + 1'b1);
        state_next      = ST_IDLE;
      end

      ST_DEQ_HEAD: begin
        // capture the head entry
        res_id_next     = rd_id;
        res_prio_next   = rd_prio;
        res_status_next = STATUS_OK;
        if (count == CW'(1)) begin
          count_next   = '0;
          done_next    = 1'b1;
          res_occ_next = '0;
          state_next   = ST_IDLE;
        end else begin
          raddr      = AW'(1);
          idx_next   = AW'(1);
          state_next = ST_DEQ_SHIFT;
        end
      end

      ST_DEQ_SHIFT: begin
        // move each entry up one slot
        we    = 1'b1;
        waddr = AW'(idx - 1'b1);
        wdata = rdata;
        if (CW'(idx) == CW'(count - 1'b1)) begin
          count_next   = CW'(count - 1'b1);
          done_next    = 1'b1;
          res_occ_next = CW'(count - 1'b1);
          state_next   = ST_IDLE;
        end else begin
          raddr    = AW'(idx + 1'b1);
          idx_next = AW'(idx + 1'b1);
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule
